@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, masked while arst_n is low
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// antecedent this cycle, consequent on the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	`ASSERT_PROP(lbl, (ante) |=> (cons), msg)

`endif

@@ sv/ccc_pkg.sv @@
`timescale 1ns / 1ps

package ccc_pkg;

	localparam logic [9:0] DUTY_MAX        = 10'd1023;
	localparam logic [9:0] DUTY_INIT       = 10'd205;
	localparam logic [4:0] ZC_BACKUP_TICKS = 5'd18;

	typedef enum logic [2:0] {
		MODE_INIT = 3'd0,
		MODE_SS   = 3'd1,
		MODE_LM   = 3'd2,
		MODE_CC   = 3'd3,
		MODE_CV   = 3'd4,
		MODE_STOP = 3'd5,
		MODE_MON  = 3'd6,
		MODE_SHUT = 3'd7
	} ccc_mode_t;

	// configuration register indexes
	localparam logic [2:0] REG_CV_SETPOINT       = 3'd0;
	localparam logic [2:0] REG_CV_TIMEOUT        = 3'd1;
	localparam logic [2:0] REG_MAX_CURRENT       = 3'd2;
	localparam logic [2:0] REG_BRANCH_LIMIT      = 3'd3;
	localparam logic [2:0] REG_LOAD_RESET_MARGIN = 3'd4;
	localparam logic [2:0] REG_LOAD_DEADBAND     = 3'd5;
	localparam logic [2:0] REG_RESTART_VOLTAGE   = 3'd6;

	typedef struct packed {
		logic [11:0] cv_setpoint;
		logic [14:0] cv_time_limit;
		logic [11:0] max_current;
		logic [11:0] branch_limit;
		logic [7:0]  load_reset_margin;
		logic [7:0]  load_deadband;
		logic [11:0] restart_voltage;
	} ccc_cfg_t;

	typedef struct packed {
		logic [11:0] vbatt_avg;
		logic [11:0] ilimit_rms;
		logic [11:0] iline_avg;
		logic        zero_cross;
		logic        avg_valid;
		logic        stop_pulse;
		logic        restart_cycle;
		logic        minute_tick;
		logic        ac_qualified;
		logic        charge_enable;
	} ccc_req_t;

	typedef struct packed {
		ccc_mode_t   mode;
		ccc_mode_t   resume_mode;
		logic [9:0]  duty;
		logic [4:0]  zc_count;
		logic [14:0] cv_left;
		logic        cv_done;
		logic        complete;
		logic [15:0] cc_elapsed;
		logic [1:0]  ac_loss;
		logic        stop_pending;
	} ccc_state_t;

	typedef struct packed {
		logic [2:0]  charge_state;
		logic [9:0]  duty_value;
		logic [11:0] current_setpoint;
		logic        complete_flag;
		logic        cv_expired;
		logic [15:0] cc_minutes;
		logic        shutdown_flag;
	} ccc_res_t;

	// add a signed step to the duty and clamp to 0..DUTY_MAX
	function automatic logic [9:0] duty_add(input logic [9:0] d, input logic signed [7:0] delta);
		logic signed [11:0] v;
		v = $signed({2'b00, d}) + $signed({{4{delta[7]}}, delta});
		if (v < 12'sd0)
			return 10'd0;
		else if (v > $signed({2'b00, DUTY_MAX}))
			return DUTY_MAX;
		else
			return v[9:0];
	endfunction

endpackage

@@ sv/cc_cv_charger_controller.sv @@
// cc/cv charger sequencer, one control tick per request
// an accepted request is held in the input register, then its state and result are registered
// throughput: one request per clock unless the result stalls; state loop closes through ccc_step
// reset: arst_n clears all control state at once; request payload and result data are not reset
`timescale 1ns / 1ps

module cc_cv_charger_controller (
	input  logic        clk,
	input  logic        arst_n,

	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [11:0] vbatt_avg,
	input  logic [11:0] ilimit_rms,
	input  logic [11:0] iline_avg,
	input  logic        zero_cross,
	input  logic        avg_valid,
	input  logic        stop_pulse,
	input  logic        restart_cycle,
	input  logic        minute_tick,
	input  logic        ac_qualified,
	input  logic        charge_enable,

	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  charge_state,
	output logic [9:0]  duty_value,
	output logic [11:0] current_setpoint,
	output logic        complete_flag,
	output logic        cv_expired,
	output logic [15:0] cc_minutes,
	output logic        shutdown_flag,

	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);
	import ccc_pkg::*;

	ccc_cfg_t   cfg;
	ccc_req_t   req_s1;
	logic       valid_s1;
	ccc_state_t state_q;
	ccc_state_t state_nxt;
	ccc_res_t   res_nxt;
	ccc_res_t   res_q;
	logic       out_valid_q;
	logic       advance;

	// configuration register file
	ccc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the held request moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	// input register refills in the same cycle it empties
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// request payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= '{vbatt_avg:      vbatt_avg,
			            ilimit_rms:     ilimit_rms,
			            iline_avg:      iline_avg,
			            zero_cross:     zero_cross,
			            avg_valid:      avg_valid,
			            stop_pulse:     stop_pulse,
			            restart_cycle:  restart_cycle,
			            minute_tick:    minute_tick,
			            ac_qualified:   ac_qualified,
			            charge_enable:  charge_enable};
		end
	end

	// one control tick: stop latch, cycle reset, minute timers, zero-cross count, state machine
	ccc_step u_step (
		.cfg (cfg),
		.req (req_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// sequencer state, committed only when a request advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_INIT, resume_mode: MODE_INIT, duty: DUTY_INIT,
			             ac_loss: 2'd2, default: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register, holds while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign charge_state     = res_q.charge_state;
	assign duty_value       = res_q.duty_value;
	assign current_setpoint = res_q.current_setpoint;
	assign complete_flag    = res_q.complete_flag;
	assign cv_expired       = res_q.cv_expired;
	assign cc_minutes       = res_q.cc_minutes;
	assign shutdown_flag    = res_q.shutdown_flag;

endmodule

@@ sv/ccc_cfg.sv @@
`timescale 1ns / 1ps

module ccc_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [14:0]      cfg_data,
	output ccc_pkg::ccc_cfg_t cfg
);
	import ccc_pkg::*;

	ccc_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{load_reset_margin: 8'd30, load_deadband: 8'd5, default: '0};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CV_SETPOINT:       cfg_q.cv_setpoint       <= cfg_data[11:0];
				REG_CV_TIMEOUT:        cfg_q.cv_time_limit     <= cfg_data;
				REG_MAX_CURRENT:       cfg_q.max_current       <= cfg_data[11:0];
				REG_BRANCH_LIMIT:      cfg_q.branch_limit      <= cfg_data[11:0];
				REG_LOAD_RESET_MARGIN: cfg_q.load_reset_margin <= cfg_data[7:0];
				REG_LOAD_DEADBAND:     cfg_q.load_deadband     <= cfg_data[7:0];
				REG_RESTART_VOLTAGE:   cfg_q.restart_voltage   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

endmodule

@@ sv/ccc_step.sv @@
`timescale 1ns / 1ps

module ccc_step (
	input  ccc_pkg::ccc_cfg_t   cfg,
	input  ccc_pkg::ccc_req_t   req,
	input  ccc_pkg::ccc_state_t cur,
	output ccc_pkg::ccc_state_t nxt,
	output ccc_pkg::ccc_res_t   res
);
	import ccc_pkg::*;

	ccc_state_t         s;
	ccc_mode_t          seen;
	logic [11:0]        amps;
	logic               zc;
	logic [4:0]         zc_inc;
	logic [12:0]        lim_reset;
	logic [12:0]        lim_band;
	logic signed [13:0] lm_floor;
	logic signed [13:0] lm_up_diff;
	logic               lm_below;
	logic [11:0]        lm_dn_diff;
	logic [7:0]         lm_dn_mag;
	logic [7:0]         lm_up_mag;
	logic [11:0]        cv_hi_diff;
	logic [11:0]        cv_lo_diff;
	logic [7:0]         cv_hi_mag;
	logic [7:0]         cv_lo_mag;

	function automatic ccc_state_t cycle_reset(input ccc_state_t st, input logic [14:0] timeout);
		ccc_state_t r;
		r             = st;
		r.mode        = MODE_INIT;
		r.resume_mode = MODE_INIT;
		r.cc_elapsed  = 16'd0;
		r.cv_left     = timeout;
		r.cv_done     = 1'b0;
		r.complete    = 1'b0;
		return r;
	endfunction

	// thresholds and capped error steps
	assign lim_reset  = {1'b0, cfg.branch_limit} + {5'b0, cfg.load_reset_margin};
	assign lim_band   = {1'b0, cfg.branch_limit} + {5'b0, cfg.load_deadband};
	assign lm_floor   = $signed({2'b00, cfg.branch_limit}) - $signed({6'b0, cfg.load_deadband});
	assign lm_up_diff = lm_floor - $signed({2'b00, req.iline_avg});
	assign lm_below   = $signed({2'b00, req.iline_avg}) < lm_floor;
	assign lm_dn_diff = req.iline_avg - cfg.branch_limit;
	assign lm_dn_mag  = (lm_dn_diff > 12'd10) ? 8'd10 : lm_dn_diff[7:0];
	assign lm_up_mag  = (lm_up_diff > 14'sd10) ? 8'd10 : lm_up_diff[7:0];
	assign cv_hi_diff = req.vbatt_avg - cfg.cv_setpoint;
	assign cv_lo_diff = cfg.cv_setpoint - req.vbatt_avg;
	assign cv_hi_mag  = (cv_hi_diff > 12'd30) ? 8'd30 : cv_hi_diff[7:0];
	assign cv_lo_mag  = (cv_lo_diff > 12'd30) ? 8'd30 : cv_lo_diff[7:0];
	assign zc_inc     = cur.zc_count + 5'd1;

	always_comb begin
		s    = cur;
		amps = cfg.max_current;
		zc   = 1'b0;
		seen = cur.mode;

		if (req.stop_pulse)
			s.stop_pending = 1'b1;
		if (req.restart_cycle)
			s = cycle_reset(s, cfg.cv_time_limit);

		// minute timers act on the mode held before any ac-loss reset
		if (req.minute_tick) begin
			seen = s.mode;
			if (req.ac_qualified)
				s.ac_loss = 2'd2;
			if (s.ac_loss != 2'd0)
				s.ac_loss = s.ac_loss - 2'd1;
			else
				s = cycle_reset(s, cfg.cv_time_limit);
			if (req.charge_enable) begin
				if (seen == MODE_CC) begin
					if (s.cc_elapsed != 16'hFFFF)
						s.cc_elapsed = s.cc_elapsed + 16'd1;
				end else if (seen == MODE_CV && !s.cv_done) begin
					if (s.cv_left <= 15'd1) begin
						s.cv_left = 15'd0;
						s.cv_done = 1'b1;
					end else begin
						s.cv_left = s.cv_left - 15'd1;
					end
				end
			end
		end

		// control tick on a crossing or on the backup count
		s.zc_count = zc_inc;
		if (req.zero_cross || zc_inc >= ZC_BACKUP_TICKS) begin
			s.zc_count = 5'd0;
			zc         = 1'b1;
		end

		unique case (s.mode)
			MODE_INIT: begin
				s.duty = DUTY_INIT;
				if (req.avg_valid)
					s.mode = (s.resume_mode != MODE_INIT) ? s.resume_mode : MODE_SS;
			end
			MODE_SS: begin
				amps = (cfg.branch_limit < cfg.max_current) ? cfg.branch_limit : cfg.max_current;
				if (s.stop_pending)
					s.mode = MODE_STOP;
				else if (s.cv_done)
					s.mode = MODE_MON;
				else if (req.vbatt_avg >= cfg.cv_setpoint)
					s.mode = MODE_CV;
				else if (req.ilimit_rms >= cfg.max_current)
					s.mode = MODE_CC;
				else if (req.iline_avg >= cfg.branch_limit)
					s.mode = MODE_LM;
				else if (zc)
					s.duty = duty_add(s.duty, 8'sd10);
			end
			MODE_LM: begin
				s.resume_mode = MODE_LM;
				if (zc) begin
					amps = cfg.branch_limit;
					if (s.stop_pending)
						s.mode = MODE_STOP;
					else if ({1'b0, req.iline_avg} > lim_reset) begin
						s.duty = DUTY_INIT;
						s.mode = MODE_SS;
					end else if (req.iline_avg > cfg.branch_limit)
						s.duty = duty_add(s.duty, 8'sd0 - $signed(lm_dn_mag));
					else if (lm_below) begin
						if (req.vbatt_avg >= cfg.cv_setpoint)
							s.mode = MODE_CV;
						else if (req.ilimit_rms >= cfg.max_current)
							s.mode = MODE_CC;
						else
							s.duty = duty_add(s.duty, $signed(lm_up_mag));
					end
				end
			end
			MODE_CC: begin
				s.resume_mode = MODE_CC;
				if (zc) begin
					if (s.stop_pending)
						s.mode = MODE_STOP;
					else if (req.vbatt_avg >= cfg.cv_setpoint)
						s.mode = MODE_CV;
					else if ({1'b0, req.iline_avg} > lim_reset) begin
						s.duty = DUTY_INIT;
						s.mode = MODE_SS;
					end else if ({1'b0, req.iline_avg} > lim_band)
						s.mode = MODE_LM;
					else if (req.ilimit_rms > cfg.max_current)
						s.duty = duty_add(s.duty, -8'sd1);
					else if (req.ilimit_rms < cfg.max_current)
						s.duty = duty_add(s.duty, 8'sd1);
				end
			end
			MODE_CV: begin
				s.resume_mode = MODE_CV;
				if (s.stop_pending)
					s.mode = MODE_STOP;
				else if (s.cv_done) begin
					s.complete = 1'b1;
					s.mode     = MODE_MON;
				end else if ({1'b0, req.iline_avg} > lim_reset) begin
					s.duty = DUTY_INIT;
					s.mode = MODE_SS;
				end else if (req.iline_avg >= cfg.branch_limit)
					s.mode = MODE_LM;
				else if (req.ilimit_rms > cfg.max_current)
					s.mode = MODE_CC;
				else if (zc) begin
					if (req.vbatt_avg > cfg.cv_setpoint)
						s.duty = duty_add(s.duty, 8'sd0 - $signed(cv_hi_mag));
					else if (req.vbatt_avg < cfg.cv_setpoint)
						s.duty = duty_add(s.duty, $signed(cv_lo_mag));
				end
			end
			MODE_STOP: begin
				if (zc) begin
					s.duty = duty_add(s.duty, -8'sd100);
					if (s.duty == 10'd0) begin
						if (s.stop_pending) begin
							s.stop_pending = 1'b0;
							s.mode         = MODE_SHUT;
						end else if (s.complete)
							s.mode = MODE_MON;
						else
							s.mode = s.resume_mode;
					end
				end
			end
			MODE_MON: begin
				s.duty = duty_add(s.duty, -8'sd1);
				if (zc) begin
					if (s.stop_pending) begin
						s.stop_pending = 1'b0;
						s.mode         = MODE_SHUT;
					end else if (s.complete) begin
						s.resume_mode = MODE_MON;
						if (req.vbatt_avg < cfg.restart_voltage) begin
							s      = cycle_reset(s, cfg.cv_time_limit);
							s.mode = MODE_CV;
						end
					end
				end
			end
			MODE_SHUT: ;
			default: ;
		endcase
	end

	assign nxt                  = s;
	assign res.charge_state     = s.mode;
	assign res.duty_value       = s.duty;
	assign res.current_setpoint = amps;
	assign res.complete_flag    = s.complete;
	assign res.cv_expired       = s.cv_done;
	assign res.cc_minutes       = s.cc_elapsed;
	assign res.shutdown_flag    = (s.mode == MODE_SHUT);

endmodule

@@ sv/ccc_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  charge_state,
	input logic [9:0]  duty_value,
	input logic        complete_flag,
	input logic        cv_expired,
	input logic        shutdown_flag
);
	import ccc_pkg::*;

	// a stalled result keeps its duty
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(duty_value), "stalled result changed")
	// a free consumer never backs up the request side
	`ASSERT_PROP(a_no_stall, !out_stall |-> !in_stall, "request stalled with free output")
	// shutdown flag follows the reported state
	`ASSERT_PROP(a_shut_flag, out_valid |-> (shutdown_flag == (charge_state == MODE_SHUT)), "shutdown flag mismatch")
	// charge complete only after the cv timer expired
	`ASSERT_PROP(a_complete, out_valid && complete_flag |-> cv_expired, "complete without cv expiry")
	// initial state always reports the start duty
	`ASSERT_PROP(a_init_duty, out_valid && (charge_state == MODE_INIT) |-> (duty_value == DUTY_INIT), "init duty wrong")

endmodule

bind cc_cv_charger_controller ccc_checker u_ccc_checker (.*);
